// ===== src/cl_pkg.sv =====
// ----------------------------------------------------------------------------
// cl_pkg: shared types for the chain link table
// Beat payloads, link entry format, operation codes and controller states.
// ----------------------------------------------------------------------------
package cl_pkg;

  localparam int ID_W = 10;

  typedef enum logic [2:0] {
    OP_LINK       = 3'd0,
    OP_CUT_AFTER  = 3'd1,
    OP_CUT_BEFORE = 3'd2,
    OP_HEAD       = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
  } in_item_t;

  typedef struct packed {
    logic            changed;
    logic [ID_W-1:0] head_id;
    logic            is_first;
    logic            is_last;
    logic            cycle_found;
  } out_item_t;

  // one link: valid bit plus neighbor id
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } link_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CUT2,
    ST_WALK,
    ST_STAT_RD,
    ST_STAT
  } state_t;

endpackage

// ===== src/chain_link_table.sv =====
// ----------------------------------------------------------------------------
// chain_link_table: doubly linked node table
// Successor and predecessor links kept in two RAMs; link, cut, head walk and
// status query operations, one result beat per input beat.
// ----------------------------------------------------------------------------
// After reset the block sweeps both link RAMs, one entry per cycle, over all
// NODES entries with in_ready low. It then handles one beat at a time: link
// and cut after read the links and write back any change, a status query reads
// the node's links, cut before also follows the predecessor link to read that
// node's successor, and a head walk makes one dependent read of the
// predecessor RAM per step (at most NODES steps on a cyclic chain). The next
// beat is accepted the cycle after the result is registered, even if that
// result has not been taken yet.
module chain_link_table #(
  parameter int NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cl_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cl_pkg::out_item_t out_data
);
  import cl_pkg::*;

  localparam int AW = $clog2(NODES);

  logic          succ_wr_en, succ_rd_en, pred_wr_en, pred_rd_en;
  logic [AW-1:0] succ_wr_addr, succ_rd_addr, pred_wr_addr, pred_rd_addr;
  link_t         succ_wr_data, succ_rd_data, pred_wr_data, pred_rd_data;

  cl_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .succ_wr_en   (succ_wr_en),
    .succ_wr_addr (succ_wr_addr),
    .succ_wr_data (succ_wr_data),
    .succ_rd_en   (succ_rd_en),
    .succ_rd_addr (succ_rd_addr),
    .succ_rd_data (succ_rd_data),
    .pred_wr_en   (pred_wr_en),
    .pred_wr_addr (pred_wr_addr),
    .pred_wr_data (pred_wr_data),
    .pred_rd_en   (pred_rd_en),
    .pred_rd_addr (pred_rd_addr),
    .pred_rd_data (pred_rd_data)
  );

  cl_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (NODES)
  ) u_succ_ram (
    .clk     (clk),
    .wr_en   (succ_wr_en),
    .wr_addr (succ_wr_addr),
    .wr_data (succ_wr_data),
    .rd_en   (succ_rd_en),
    .rd_addr (succ_rd_addr),
    .rd_data (succ_rd_data)
  );

  cl_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (NODES)
  ) u_pred_ram (
    .clk     (clk),
    .wr_en   (pred_wr_en),
    .wr_addr (pred_wr_addr),
    .wr_data (pred_wr_data),
    .rd_en   (pred_rd_en),
    .rd_addr (pred_rd_addr),
    .rd_data (pred_rd_data)
  );

`ifndef SYNTHESIS
  // clearing sweep starts right after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one beat in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // a new link always writes both halves together
  a_link_pair: assert property (@(posedge clk) disable iff (!rst_n)
    succ_wr_en && succ_wr_data.valid |->
      pred_wr_en && pred_wr_data.valid &&
      (pred_wr_data.id == ID_W'(succ_wr_addr)))
    else $error("half-written link");

  // stored links never point at a node outside the table
  a_link_range: assert property (@(posedge clk) disable iff (!rst_n)
    succ_wr_en && succ_wr_data.valid |-> 32'(succ_wr_data.id) < NODES)
    else $error("link to out-of-range node");
`endif

endmodule

// ===== src/cl_ram.sv =====
// ----------------------------------------------------------------------------
// cl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered, held between reads.
// ----------------------------------------------------------------------------
module cl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cl_ctrl.sv =====
// ----------------------------------------------------------------------------
// cl_ctrl: sequencer for the chain link table
// Clears both link memories after reset, then runs a link or cut as a read /
// modify / write-back, a head walk or query as reads; one result beat each.
// ----------------------------------------------------------------------------
module cl_ctrl #(
  parameter int NODES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cl_pkg::in_item_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cl_pkg::out_item_t        out_data,
  output logic                     succ_wr_en,
  output logic [$clog2(NODES)-1:0] succ_wr_addr,
  output cl_pkg::link_t            succ_wr_data,
  output logic                     succ_rd_en,
  output logic [$clog2(NODES)-1:0] succ_rd_addr,
  input  cl_pkg::link_t            succ_rd_data,
  output logic                     pred_wr_en,
  output logic [$clog2(NODES)-1:0] pred_wr_addr,
  output cl_pkg::link_t            pred_wr_data,
  output logic                     pred_rd_en,
  output logic [$clog2(NODES)-1:0] pred_rd_addr,
  input  cl_pkg::link_t            pred_rd_data
);
  import cl_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  function automatic logic node_ok(input logic [ID_W-1:0] id);
    return 32'(id) < NODES;
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [ID_W-1:0] a_r, a_nxt;
  logic [ID_W-1:0] b_r, b_nxt;
  logic [ID_W-1:0] cur_r, cur_nxt;
  logic [CW-1:0]   steps_r, steps_nxt;
  logic            changed_r, changed_nxt;
  logic [ID_W-1:0] head_r, head_nxt;
  logic            cycle_r, cycle_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  link_t           empty_link;

  assign empty_link = '{valid: 1'b0, id: '0};
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    changed_nxt   = changed_r;
    head_nxt      = head_r;
    cycle_nxt     = cycle_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    succ_wr_en    = 1'b0;
    succ_wr_addr  = AW'(a_r);
    succ_wr_data  = empty_link;
    succ_rd_en    = 1'b0;
    succ_rd_addr  = AW'(a_r);
    pred_wr_en    = 1'b0;
    pred_wr_addr  = AW'(b_r);
    pred_wr_data  = empty_link;
    pred_rd_en    = 1'b0;
    pred_rd_addr  = AW'(a_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        succ_wr_en   = 1'b1;
        succ_wr_addr = clr_cnt_r;
        pred_wr_en   = 1'b1;
        pred_wr_addr = clr_cnt_r;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.op;
          a_nxt       = in_data.first_id;
          b_nxt       = in_data.second_id;
          cur_nxt     = in_data.first_id;
          steps_nxt   = '0;
          changed_nxt = 1'b0;
          head_nxt    = '0;
          cycle_nxt   = 1'b0;
          succ_rd_en   = 1'b1;
          succ_rd_addr = AW'(in_data.first_id);
          pred_rd_en   = 1'b1;
          pred_rd_addr = (in_data.op == OP_HEAD) ? AW'(in_data.first_id)
                                                 : AW'(in_data.second_id);
          case (in_data.op)
            OP_LINK, OP_CUT_AFTER, OP_CUT_BEFORE: state_nxt = ST_LOOKUP;
            OP_HEAD:                              state_nxt = ST_WALK;
            default:                              state_nxt = ST_STAT_RD;
          endcase
        end
      end

      // succ[a] and pred[b] are on the read ports
      ST_LOOKUP: begin
        state_nxt = ST_STAT_RD;
        case (op_r)
          OP_LINK: begin
            if (node_ok(a_r) && node_ok(b_r) && !succ_rd_data.valid &&
                !pred_rd_data.valid) begin
              succ_wr_en   = 1'b1;
              succ_wr_addr = AW'(a_r);
              succ_wr_data = '{valid: 1'b1, id: b_r};
              pred_wr_en   = 1'b1;
              pred_wr_addr = AW'(b_r);
              pred_wr_data = '{valid: 1'b1, id: a_r};
              changed_nxt  = 1'b1;
            end
          end
          OP_CUT_AFTER: begin
            if (node_ok(a_r) && succ_rd_data.valid) begin
              succ_wr_en   = 1'b1;
              succ_wr_addr = AW'(a_r);
              pred_wr_en   = node_ok(succ_rd_data.id);
              pred_wr_addr = AW'(succ_rd_data.id);
              changed_nxt  = 1'b1;
            end
          end
          OP_CUT_BEFORE: begin
            // cut after the predecessor of b: fetch its successor link
            if (node_ok(b_r) && pred_rd_data.valid) begin
              cur_nxt      = pred_rd_data.id;
              succ_rd_en   = 1'b1;
              succ_rd_addr = AW'(pred_rd_data.id);
              state_nxt    = ST_CUT2;
            end
          end
          default: ;
        endcase
      end

      ST_CUT2: begin
        if (node_ok(cur_r) && succ_rd_data.valid) begin
          succ_wr_en   = 1'b1;
          succ_wr_addr = AW'(cur_r);
          pred_wr_en   = node_ok(succ_rd_data.id);
          pred_wr_addr = AW'(succ_rd_data.id);
          changed_nxt  = 1'b1;
        end
        state_nxt = ST_STAT_RD;
      end

      // pred[cur] is on the read port
      ST_WALK: begin
        if (!node_ok(cur_r) || !pred_rd_data.valid) begin
          head_nxt  = cur_r;
          state_nxt = ST_STAT_RD;
        end else if (steps_r == CW'(NODES)) begin
          cycle_nxt = 1'b1;
          head_nxt  = '0;
          state_nxt = ST_STAT_RD;
        end else begin
          cur_nxt      = pred_rd_data.id;
          steps_nxt    = steps_r + 1'b1;
          pred_rd_en   = 1'b1;
          pred_rd_addr = AW'(pred_rd_data.id);
        end
      end

      ST_STAT_RD: begin
        succ_rd_en   = 1'b1;
        succ_rd_addr = AW'(a_r);
        pred_rd_en   = 1'b1;
        pred_rd_addr = AW'(a_r);
        state_nxt    = ST_STAT;
      end

      // read data holds here until the output register frees up
      ST_STAT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.changed     = changed_r;
          out_nxt.head_id     = head_r;
          out_nxt.is_first    = !(node_ok(a_r) && pred_rd_data.valid);
          out_nxt.is_last     = !(node_ok(a_r) && succ_rd_data.valid);
          out_nxt.cycle_found = cycle_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    cur_r     <= cur_nxt;
    steps_r   <= steps_nxt;
    changed_r <= changed_nxt;
    head_r    <= head_nxt;
    cycle_r   <= cycle_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression for chain_link_table
// Drives link, cut, head walk and query beats through valid/ready with random
// gaps on both sides, mirrors the link tables in a local model and checks
// every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  import cl_pkg::*;

  localparam int NODES = 1024;
  // slowest legal run: every beat a cyclic walk plus the longest gap and stall
  localparam int CYCLE_LIMIT = 1600 * (NODES + 100) * 3 + NODES;

  // unused op codes, handled as a plain status query
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  link_t     succ_tbl [NODES];
  link_t     pred_tbl [NODES];
  out_item_t pending_status [$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        cycle_cnt = 0;
  int        ready_hold = 0;
  bit        no_gaps = 1'b0;

  chain_link_table #(.NODES(NODES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("chain_link_table regression: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------- link table model ----------------

  function automatic bit sever_after(logic [ID_W-1:0] node);
    logic [ID_W-1:0] nxt;
    if (!succ_tbl[node].valid) return 1'b0;
    nxt = succ_tbl[node].id;
    succ_tbl[node] = '0;
    pred_tbl[nxt] = '0;
    return 1'b1;
  endfunction

  function automatic out_item_t apply_link_op(in_item_t item);
    out_item_t       res;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic [ID_W-1:0] cur;
    int              hops;
    bit              done;
    a = item.first_id;
    b = item.second_id;
    res = '0;
    case (item.op)
      OP_LINK: begin
        if (!succ_tbl[a].valid && !pred_tbl[b].valid) begin
          succ_tbl[a] = '{valid: 1'b1, id: b};
          pred_tbl[b] = '{valid: 1'b1, id: a};
          res.changed = 1'b1;
        end
      end
      OP_CUT_AFTER: res.changed = sever_after(a);
      OP_CUT_BEFORE: begin
        if (pred_tbl[b].valid) res.changed = sever_after(pred_tbl[b].id);
      end
      OP_HEAD: begin
        cur = a;
        hops = 0;
        done = 1'b0;
        while (!done && pred_tbl[cur].valid) begin
          if (hops >= NODES) begin
            res.cycle_found = 1'b1;
            done = 1'b1;
          end else begin
            cur = pred_tbl[cur].id;
            hops++;
          end
        end
        res.head_id = res.cycle_found ? '0 : cur;
      end
      default: ;
    endcase
    res.is_first = !pred_tbl[a].valid;
    res.is_last = !succ_tbl[a].valid;
    return res;
  endfunction

  // ---------------- input side ----------------

  task automatic send_item(input logic [2:0] op, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b);
    in_item_t item;
    int       gap;
    item.op = op;
    item.first_id = a;
    item.second_id = b;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    pending_status = {pending_status, apply_link_op(item)};
    beats_sent++;
  endtask

  // ---------------- result side ----------------

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("changed", ID_W'(want.changed), ID_W'(out_data.changed));
        check_field("head_id", want.head_id, out_data.head_id);
        check_field("is_first", ID_W'(want.is_first), ID_W'(out_data.is_first));
        check_field("is_last", ID_W'(want.is_last), ID_W'(out_data.is_last));
        check_field("cycle_found", ID_W'(want.cycle_found),
                    ID_W'(out_data.cycle_found));
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      ready_hold <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  // ---------------- tests ----------------

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, NODES - 1));
  endfunction

  task automatic test_directed();
    send_item(OP_QUERY, 10'd0, 10'd0);
    send_item(OP_QUERY, 10'd1023, 10'd1023);
    send_item(OP_HEAD, 10'd1023, 10'd0);
    send_item(OP_LINK, 10'd0, 10'd1023);
    send_item(OP_LINK, 10'd0, 10'd5);      // source already has a successor
    send_item(OP_LINK, 10'd7, 10'd1023);   // target already has a predecessor
    send_item(OP_HEAD, 10'd1023, 10'd0);
    send_item(OP_LINK, 10'd1023, 10'd0);   // closes a two node loop
    send_item(OP_HEAD, 10'd0, 10'd1023);
    send_item(OP_CUT_BEFORE, 10'd1023, 10'd0);
    send_item(OP_QUERY, 10'd1023, 10'd0);
    send_item(OP_CUT_AFTER, 10'd0, 10'd1023);
    send_item(OP_CUT_AFTER, 10'd0, 10'd0);     // nothing to cut
    send_item(OP_CUT_BEFORE, 10'd1023, 10'd0); // nothing to cut
    send_item(OP_LINK, 10'd341, 10'd341);      // self link
    send_item(OP_HEAD, 10'd341, 10'd682);
    send_item(OP_CUT_BEFORE, 10'd0, 10'd341);
    send_item(OP_LINK, 10'd682, 10'd341);
    send_item(OP_LINK, 10'd341, 10'd512);
    send_item(OP_HEAD, 10'd512, 10'd1023);
    send_item(OP_RSVD5, 10'd682, 10'd341);
    send_item(OP_RSVD6, 10'd512, 10'd0);
    send_item(OP_RSVD7, 10'd341, 10'd1023);
    send_item(OP_CUT_AFTER, 10'd682, 10'd0);
    send_item(OP_CUT_AFTER, 10'd341, 10'd0);
  endtask

  // build a chain of distinct nodes, poke at it, then take it apart
  task automatic run_chain(input int len, input bit close_loop);
    logic [ID_W-1:0] ids [16];
    logic [ID_W-1:0] start;
    int              stride;
    int              k;
    start = any_id();
    stride = $urandom_range(1, 40);
    for (int i = 0; i < len; i++) ids[i] = start + ID_W'(i * stride);
    for (int i = 0; i < len - 1; i++) send_item(OP_LINK, ids[i], ids[i + 1]);
    if (close_loop) send_item(OP_LINK, ids[len - 1], ids[0]);
    send_item(OP_HEAD, ids[len - 1], any_id());
    repeat ($urandom_range(2, 6)) begin
      k = $urandom_range(0, len - 1);
      case ($urandom_range(0, 5))
        0: send_item(OP_HEAD, ids[k], any_id());
        1: send_item(OP_QUERY, ids[k], any_id());
        2: send_item(OP_CUT_AFTER, ids[k], any_id());
        3: send_item(OP_CUT_BEFORE, any_id(), ids[k]);
        4: send_item(OP_LINK, ids[k], ids[(k + 1) % len]);
        default: send_item(3'($urandom_range(5, 7)), ids[k], any_id());
      endcase
    end
    if (close_loop) begin
      send_item(OP_HEAD, ids[$urandom_range(0, len - 1)], any_id());
      send_item(OP_CUT_BEFORE, any_id(), ids[0]);
      send_item(OP_HEAD, ids[len - 1], any_id());
    end
    for (int i = 0; i < len; i++) send_item(OP_CUT_AFTER, ids[i], any_id());
  endtask

  task automatic test_chains(input int target);
    target += beats_sent;
    while (beats_sent < target) run_chain($urandom_range(2, 16), 1'b0);
  endtask

  task automatic test_cycles(input int rounds);
    repeat (rounds) run_chain($urandom_range(1, 6), 1'b1);
  endtask

  task automatic test_back_to_back(input int target);
    no_gaps = 1'b1;
    target += beats_sent;
    while (beats_sent < target) run_chain($urandom_range(2, 12), $urandom_range(0, 9) == 0);
    no_gaps = 1'b0;
  endtask

  // random ops crowded into a small window of nodes so links collide
  task automatic test_noise(input int count);
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) base = any_id();
      a = ($urandom_range(0, 9) == 0) ? any_id() : base + ID_W'($urandom_range(0, 15));
      b = ($urandom_range(0, 9) == 0) ? any_id() : base + ID_W'($urandom_range(0, 15));
      send_item(3'($urandom_range(0, 7)), a, b);
    end
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      succ_tbl[i] = '0;
      pred_tbl[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_chains(650);
    test_cycles(12);
    test_back_to_back(200);
    test_noise(320);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (NODES + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("chain_link_table regression: pass");
    end else begin
      $display("chain_link_table regression: fail");
    end
    $finish;
  end

endmodule
